// ===== rtl/core/fftwa_pkg.sv =====
// package for the fragment flow table: widths, commands, entry layout
// used by the top, sequencer and datapath modules under rtl/core
package fftwa_pkg;

   localparam int BucketsDefault  = 1024;
   localparam int WaysDefault     = 4;
   // time wrap is fixed: stamps and ages are 8 bits and wrap on their own
   localparam int TimeWrapDefault = 256;

   localparam int EntryWidth = 1 + 64 + 24 + 8 + 32 + 17;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_ATTACH = 2'd3
   } cmd_type;

   localparam logic [0:0] REG_AGE_LIMIT = 1'b0;
   localparam logic [0:0] REG_TO_HOST   = 1'b1;

   typedef struct packed {
      logic        valid;
      logic [63:0] addrs;
      logic [23:0] idp;
      logic [7:0]  stamp;
      logic [31:0] ports;
      logic        rule_valid;
      logic [15:0] rule;
   } entry_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic decide;
      logic finish;
   } ctl_type;

endpackage

// ===== rtl/core/fragment_flow_table_with_aging.sv =====
// Fragment flow table with aging: an item is accepted only while the sequencer is idle
// and passes three steps (bucket read from the way memories, compare and write back,
// output load); its result beat is presented once the output load is done, and a new
// item is taken only after the last one has left its output step. A result
// left waiting on rsp_tready holds the following item in its output step, and the
// input stalls until the output frees. After reset a clearing pass over all bucket rows
// runs before the first item is accepted; write configuration only while no item is in
// flight. The time wrap is fixed at 256 seconds.
// depends on fftwa_pkg, fftwa_ctrl, fftwa_dp
module fragment_flow_table_with_aging import fftwa_pkg::*; #(
   parameter int BUCKETS   = BucketsDefault,
   parameter int WAYS      = WaysDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[1:0] src_addr[33:2] dst_addr[65:34] ip_ident[81:66] protocol[89:82]
   // src_port[105:90] dst_port[121:106] now_seconds[129:122] rule_present[130]
   // rule_handle[146:131] action_code[154:147]
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // hit[0] way[2:1] evicted_live[3] stored_rule_valid[4] stored_rule[20:5]
   // stored_src_port[36:21] stored_dst_port[52:37] action_out[60:53]
   output logic [63:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   logic [7:0] age_limit_ff, to_host_ff;
   logic       wr;
   ctl_type    ctl;
   logic       clear_done;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[1:0] == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= 8'd3;
         to_host_ff   <= 8'd0;
      end else if (wr) begin
         if (csr_paddr[2] == REG_AGE_LIMIT) begin
            age_limit_ff <= csr_pwdata[7:0];
         end else begin
            to_host_ff <= csr_pwdata[7:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'd0) begin
         csr_prdata[7:0] = (csr_paddr[2] == REG_TO_HOST) ? to_host_ff : age_limit_ff;
      end
   end

   fftwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .clear_done(clear_done),
      .ctl       (ctl)
   );

   fftwa_dp #(.Buckets(BUCKETS), .Ways(WAYS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .clear_done       (clear_done),
      .command          (req_tdata[1:0]),
      .src_addr         (req_tdata[33:2]),
      .dst_addr         (req_tdata[65:34]),
      .ip_ident         (req_tdata[81:66]),
      .protocol         (req_tdata[89:82]),
      .src_port         (req_tdata[105:90]),
      .dst_port         (req_tdata[121:106]),
      .now_seconds      (req_tdata[129:122]),
      .rule_present     (req_tdata[130]),
      .rule_handle      (req_tdata[146:131]),
      .action_code      (req_tdata[154:147]),
      .age_limit        (age_limit_ff),
      .to_host_action   (to_host_ff),
      .hit              (rsp_tdata[0]),
      .way              (rsp_tdata[2:1]),
      .evicted_live     (rsp_tdata[3]),
      .stored_rule_valid(rsp_tdata[4]),
      .stored_rule      (rsp_tdata[20:5]),
      .stored_src_port  (rsp_tdata[36:21]),
      .stored_dst_port  (rsp_tdata[52:37]),
      .action_out       (rsp_tdata[60:53])
   );

   assign rsp_tdata[63:61] = 3'd0;
endmodule

// ===== rtl/core/fftwa_ram.sv =====
// generic single-port-write, registered-read ram
// no dependencies
module fftwa_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/core/fftwa_ctrl.sv =====
// sequencer for one table operation: read bucket, decide and write, present result
// depends on fftwa_pkg
module fftwa_ctrl import fftwa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  logic    clear_done,
   output ctl_type ctl
);
   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_OUT    = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      accept;

   // an item may enter when idle
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      ctl          = '0;
      ctl.capture  = accept;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            ctl.decide = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // result waits in the decide register until the output frees
            if (!out_valid_ff || rsp_tready) begin
               ctl.finish   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

// ===== rtl/core/fftwa_dp.sv =====
// datapath: bucket hash, way memories, match, aging, victim choice, result register
// depends on fftwa_pkg and fftwa_ram
module fftwa_dp import fftwa_pkg::*; #(
   parameter int Buckets  = BucketsDefault,
   parameter int Ways     = WaysDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   output logic        clear_done,
   input  logic [1:0]  command,
   input  logic [31:0] src_addr,
   input  logic [31:0] dst_addr,
   input  logic [15:0] ip_ident,
   input  logic [7:0]  protocol,
   input  logic [15:0] src_port,
   input  logic [15:0] dst_port,
   input  logic [7:0]  now_seconds,
   input  logic        rule_present,
   input  logic [15:0] rule_handle,
   input  logic [7:0]  action_code,
   input  logic [7:0]  age_limit,
   input  logic [7:0]  to_host_action,
   output logic        hit,
   output logic [1:0]  way,
   output logic        evicted_live,
   output logic        stored_rule_valid,
   output logic [15:0] stored_rule,
   output logic [15:0] stored_src_port,
   output logic [15:0] stored_dst_port,
   output logic [7:0]  action_out
);
   localparam int BW = (Buckets > 1) ? $clog2(Buckets) : 1;
   localparam int WW = (Ways > 1) ? $clog2(Ways) : 1;
   localparam int TW = (TimeWrapDefault > 1) ? $clog2(TimeWrapDefault) : 1;
   localparam logic [BW:0] LastBucket = (BW+1)'(Buckets - 1);

   // captured request
   cmd_type       cmd_ff;
   logic [63:0]   addrs_ff;
   logic [23:0]   idp_ff;
   logic [TW-1:0] now_ff;
   logic [31:0]   ports_ff;
   logic          rpres_ff;
   logic [15:0]   rhandle_ff;
   logic [7:0]    act_ff;
   logic [BW-1:0] bucket_ff;

   logic [31:0]   hash;
   logic [BW-1:0] bucket_in;
   logic [BW:0]   masked;

   assign hash   = src_addr ^ dst_addr ^ {16'd0, ip_ident} ^ {24'd0, protocol};
   assign masked = {1'b0, hash[BW-1:0]} & LastBucket;
   // masked value is at most Buckets - 1, since it is ANDed with LastBucket
   assign bucket_in = (masked >= (BW+1)'(Buckets)) ? BW'(masked - (BW+1)'(Buckets))
                                                   : masked[BW-1:0];

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff     <= cmd_type'(command);
         addrs_ff   <= {src_addr, dst_addr};
         idp_ff     <= {ip_ident, protocol};
         now_ff     <= now_seconds[TW-1:0];
         ports_ff   <= {src_port, dst_port};
         rpres_ff   <= rule_present;
         rhandle_ff <= rule_handle;
         act_ff     <= action_code;
         bucket_ff  <= bucket_in;
      end
   end

   // clearing pass over the bucket rows after reset
   logic [BW:0] clr_ff;
   logic        clearing;
   assign clearing   = (clr_ff < (BW+1)'(Buckets));
   assign clear_done = !clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (clearing) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   entry_type rd [Ways];
   entry_type wr_data;
   logic [Ways-1:0] wr_en;
   logic [BW-1:0]   wr_addr;
   logic [BW-1:0]   rd_addr;

   assign rd_addr = bucket_in;

   for (genvar g = 0; g < Ways; g++) begin : g_way
      fftwa_ram #(.Width(EntryWidth), .Depth(Buckets)) u_ram (
         .clock  (clock),
         .wr_en  (wr_en[g]),
         .wr_addr(wr_addr),
         .wr_data(wr_data),
         .rd_addr(rd_addr),
         .rd_data(rd[g])
      );
   end

   // match and age per way
   logic [Ways-1:0] match_v, free_v;
   logic [TW-1:0]   age [Ways];

   always_comb begin
      for (int i = 0; i < Ways; i++) begin
         match_v[i] = rd[i].valid && rd[i].addrs == addrs_ff && rd[i].idp == idp_ff;
         age[i]     = now_ff - rd[i].stamp[TW-1:0];
         free_v[i]  = !rd[i].valid || match_v[i] || (8'(age[i]) >= age_limit);
      end
   end

   // first-set search and oldest search, combinational on the read ways and used in the decide step
   logic [WW-1:0] match_w, free_w, old_w, victim_w;
   logic          any_match, any_free;
   logic [TW-1:0] old_a;

   always_comb begin
      match_w   = '0;
      any_match = 1'b0;
      free_w    = '0;
      any_free  = 1'b0;
      old_w     = '0;
      old_a     = age[0];
      for (int i = Ways - 1; i >= 0; i--) begin
         if (match_v[i]) begin
            match_w   = WW'(i);
            any_match = 1'b1;
         end
         if (free_v[i]) begin
            free_w   = WW'(i);
            any_free = 1'b1;
         end
      end
      for (int i = 1; i < Ways; i++) begin
         if (age[i] > old_a) begin
            old_a = age[i];
            old_w = WW'(i);
         end
      end
      victim_w = any_free ? free_w : old_w;
   end

   entry_type sel, newent;
   logic [WW-1:0] tw;
   logic          do_write, res_hit;

   always_comb begin
      tw       = (cmd_ff == CMD_ADD) ? victim_w : match_w;
      sel      = rd[tw];
      newent   = sel;
      do_write = 1'b0;
      res_hit  = 1'b0;
      unique case (cmd_ff)
         CMD_ADD: begin
            res_hit           = 1'b1;
            do_write          = 1'b1;
            newent.valid      = 1'b1;
            newent.addrs      = addrs_ff;
            newent.idp        = idp_ff;
            newent.stamp      = 8'(now_ff);
            newent.ports      = ports_ff;
            newent.rule_valid = rpres_ff;
            newent.rule       = rpres_ff ? rhandle_ff : 16'd0;
         end
         CMD_REMOVE: begin
            res_hit  = any_match;
            do_write = any_match;
            newent   = '0;
         end
         CMD_LOOKUP: begin
            res_hit = any_match;
         end
         CMD_ATTACH: begin
            res_hit = any_match;
            if (any_match && !sel.rule_valid && rpres_ff) begin
               do_write          = 1'b1;
               newent.rule_valid = 1'b1;
               newent.rule       = rhandle_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      wr_en   = '0;
      wr_addr = bucket_ff;
      wr_data = newent;
      if (clearing) begin
         wr_en   = '1;
         wr_addr = clr_ff[BW-1:0];
         wr_data = '0;
      end else if (ctl.decide && do_write) begin
         wr_en[tw] = 1'b1;
      end
   end

   // result register: filled at decide, held while output waits
   entry_type     shown;
   logic          hit_ff, ev_ff;
   logic [1:0]    way_ff;
   logic [7:0]    act_out_ff;
   entry_type     shown_ff;

   assign shown = (cmd_ff == CMD_REMOVE) ? sel : newent;

   always_ff @(posedge clock) begin
      if (ctl.decide) begin
         hit_ff     <= res_hit;
         way_ff     <= res_hit ? 2'(tw) : 2'd0;
         ev_ff      <= (cmd_ff == CMD_ADD) && !any_free;
         act_out_ff <= (cmd_ff == CMD_ADD) ? (rpres_ff ? act_ff : to_host_action) : 8'd0;
         shown_ff   <= res_hit ? shown : '0;
      end
   end

   // output stage: copied once per item so the next request cannot disturb it
   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         hit               <= hit_ff;
         way               <= way_ff;
         evicted_live      <= ev_ff;
         action_out        <= act_out_ff;
         stored_rule_valid <= shown_ff.rule_valid;
         stored_rule       <= shown_ff.rule;
         stored_src_port   <= shown_ff.ports[31:16];
         stored_dst_port   <= shown_ff.ports[15:0];
      end
   end
endmodule
